FILE: rtl/rgbed_pkg.sv
// ----------------------------------------------------------------------------
// rgbed_pkg
// Shared types and constants for the RGB error diffusion dither.
// ----------------------------------------------------------------------------
package rgbed_pkg;

	localparam int MAX_WIDTH_DEF = 1024;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam int IMG_W_W    = 11;
	localparam int IMG_H_W    = 12;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

	localparam logic [IMG_W_W-1:0] RESET_WIDTH  = 11'd384;
	localparam logic [IMG_H_W-1:0] RESET_HEIGHT = 12'd216;

	// diffused error, always within -127..127
	typedef logic signed [7:0] err_t;

	typedef struct packed {
		err_t red;
		err_t green;
		err_t blue;
	} err3_t;

	typedef struct packed {
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
	} pixel_t;

	typedef struct packed {
		logic out_red;
		logic out_green;
		logic out_blue;
		logic end_of_frame;
	} result_t;

	// where the pixel sits in the image
	typedef struct packed {
		logic has_right;
		logic has_below;
		logic first_col;
		logic first_row;
	} pos_t;

	// per-channel results and next state
	typedef struct packed {
		logic dot;
		err_t right;
		err_t below_left;
		err_t below_sum;
		err_t below_right;
		err_t below;
	} chan_t;

endpackage

FILE: rtl/rgbed_line_store.sv
// ----------------------------------------------------------------------------
// rgbed_line_store
// Error line memory: one write and one registered read per cycle, with
// write-to-read forwarding on an address match.
// ----------------------------------------------------------------------------
module rgbed_line_store #(
	parameter int DEPTH = rgbed_pkg::MAX_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [$clog2(DEPTH)-1:0]          waddr,
	input  rgbed_pkg::err3_t                  wdata,
	input  logic                              re,
	input  logic [$clog2(DEPTH)-1:0]          raddr,
	output rgbed_pkg::err3_t                  rdata
);
	import rgbed_pkg::*;

	err3_t mem [DEPTH];
	err3_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			// forward a value written in the same cycle
			if (we && (waddr == raddr)) begin
				rdata_q <= wdata;
			end else begin
				rdata_q <= mem[raddr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/rgbed_channel.sv
// ----------------------------------------------------------------------------
// rgbed_channel
// One color channel: adjust, clamp, threshold, and split the error into
// the four neighbor shares.
// ----------------------------------------------------------------------------
module rgbed_channel (
	input  logic [7:0]        pix,
	input  rgbed_pkg::err_t   carry,
	input  rgbed_pkg::err_t   above,
	input  rgbed_pkg::err_t   part_below,
	input  rgbed_pkg::err_t   part_below_right,
	input  rgbed_pkg::pos_t   pos,
	output rgbed_pkg::chan_t  res
);
	import rgbed_pkg::*;

	localparam logic [3:0] K_RIGHT       = 4'd7;
	localparam logic [3:0] K_BELOW_LEFT  = 4'd3;
	localparam logic [3:0] K_BELOW       = 4'd5;
	localparam logic [3:0] K_BELOW_RIGHT = 4'd1;

	// e * k / 16, truncated toward zero
	function automatic err_t share16(input err_t e, input logic [3:0] k);
		logic signed [11:0] p;
		logic signed [11:0] q;
		begin
			p = $signed({{4{e[7]}}, e}) * $signed({8'b0, k});
			q = p[11] ? (p + 12'sd15) : p;
			share16 = err_t'(q >>> 4);
		end
	endfunction

	logic [9:0] adj_raw;
	logic [7:0] adj;
	logic [8:0] e9;
	err_t       e;
	err_t       s_right;
	err_t       s_below_left;
	err_t       s_below;
	err_t       s_below_right;
	err_t       below;

	always_comb begin
		// two's complement sum; true range is -124..379
		adj_raw = {2'b00, pix} + {{2{carry[7]}}, carry}
			+ (pos.first_row ? 10'd0 : {{2{above[7]}}, above});
		if (adj_raw[9]) begin
			adj = 8'd0;
		end else if (adj_raw[8]) begin
			adj = 8'd255;
		end else begin
			adj = adj_raw[7:0];
		end
		e9 = adj[7] ? ({1'b0, adj} - 9'd255) : {1'b0, adj};
		e  = $signed(e9[7:0]);

		s_right       = share16(e, K_RIGHT);
		s_below_left  = share16(e, K_BELOW_LEFT);
		s_below       = share16(e, K_BELOW);
		s_below_right = share16(e, K_BELOW_RIGHT);
		below         = part_below_right + s_below;

		res.dot        = adj[7];
		res.right      = pos.has_right ? s_right : 8'sd0;
		res.below_left = part_below + s_below_left;
		res.below      = below;
		if (pos.has_below) begin
			res.below_sum   = pos.has_right ? below : 8'sd0;
			res.below_right = pos.has_right ? s_below_right : 8'sd0;
		end else begin
			res.below_sum   = 8'sd0;
			res.below_right = 8'sd0;
		end
	end

endmodule

FILE: rtl/rgb_error_diffusion_dither.sv
// ----------------------------------------------------------------------------
// rgb_error_diffusion_dither
// Floyd-Steinberg error diffusion on RGB pixels in raster order.
// ----------------------------------------------------------------------------
// Takes one RGB pixel word per clock while the output is not stalled and
// returns one word of three dithered bits plus an end-of-frame flag for each
// through the compute stage and output registers. The rate is one word per
// cycle, set by the single compute stage and the line store, which is read
// once and written at most once per pixel. Errors for the next row sit in a
// MAX_WIDTH-entry memory (the last column's entry is held in a register). A
// write to image_width or image_height restarts the frame; write them only while
// the block is idle. The line store needs no clearing: the first row ignores it.
module rgb_error_diffusion_dither #(
	parameter int MAX_WIDTH = rgbed_pkg::MAX_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rgbed_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rgbed_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  rgbed_pkg::pixel_t                 in_word,
	output logic                              out_valid,
	input  logic                              out_ready,
	output rgbed_pkg::result_t                out_word
);
	import rgbed_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int EW = $clog2(MAX_WIDTH + 1);

	logic [IMG_W_W-1:0] width_q;
	logic [IMG_H_W-1:0] height_q;
	logic [EW-1:0]      eff_w;
	logic [IMG_H_W-1:0] eff_h;
	logic [AW-1:0]      col_q;
	logic [IMG_H_W-1:0] row_q;
	logic               last_col;
	logic               last_row;
	logic               restart;

	logic               v_s1;
	pixel_t             pix_s1;
	pos_t               pos_s1;
	logic [AW-1:0]      waddr_s1;

	err3_t              carry_q;
	err3_t              pbs_q;
	err3_t              pbrs_q;
	err3_t              tail_q;
	err3_t              rd_data;
	err3_t              above;
	err3_t              wdata;

	chan_t              res_r;
	chan_t              res_g;
	chan_t              res_b;

	logic               in_acc;
	logic               adv;
	logic               mem_we;
	logic               tail_we;

	logic               out_valid_q;
	result_t            out_word_q;

	// effective frame size
	always_comb begin
		if (width_q == '0) begin
			eff_w = EW'(1);
		end else if ({21'b0, width_q} > 32'(MAX_WIDTH)) begin
			eff_w = EW'(MAX_WIDTH);
		end else begin
			eff_w = EW'(width_q);
		end
		eff_h = (height_q == '0) ? 12'd1 : height_q;
	end

	assign last_col = (EW'(col_q) + EW'(1)) >= eff_w;
	assign last_row = ({1'b0, row_q} + 13'd1) >= {1'b0, eff_h};

	assign adv      = v_s1 && (!out_valid_q || out_ready);
	assign in_ready = !v_s1 || adv;
	assign in_acc   = in_valid && in_ready;
	assign restart  = cfg_we && ((cfg_index == CFG_IMAGE_WIDTH) ||
		(cfg_index == CFG_IMAGE_HEIGHT));

	// registers and position of the next word to enter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RESET_WIDTH;
			height_q <= RESET_HEIGHT;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata[IMG_W_W-1:0];
				CFG_IMAGE_HEIGHT: height_q <= cfg_wdata[IMG_H_W-1:0];
				default: ;
			endcase
			if (restart) begin
				col_q <= '0;
				row_q <= '0;
			end
		end else if (in_acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : (row_q + 12'd1);
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_acc) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1           <= in_word;
			pos_s1.has_right <= !last_col;
			pos_s1.has_below <= !last_row;
			pos_s1.first_col <= (col_q == '0);
			pos_s1.first_row <= (row_q == '0);
			waddr_s1         <= col_q - AW'(1);
		end
	end

	rgbed_line_store #(
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (waddr_s1),
		.wdata (wdata),
		.re    (in_acc),
		.raddr (col_q),
		.rdata (rd_data)
	);

	// the last column's error lives in the tail register
	assign above = pos_s1.has_right ? rd_data : tail_q;

	rgbed_channel u_red (
		.pix              (pix_s1.in_red),
		.carry            (carry_q.red),
		.above            (above.red),
		.part_below       (pbs_q.red),
		.part_below_right (pbrs_q.red),
		.pos              (pos_s1),
		.res              (res_r)
	);

	rgbed_channel u_green (
		.pix              (pix_s1.in_green),
		.carry            (carry_q.green),
		.above            (above.green),
		.part_below       (pbs_q.green),
		.part_below_right (pbrs_q.green),
		.pos              (pos_s1),
		.res              (res_g)
	);

	rgbed_channel u_blue (
		.pix              (pix_s1.in_blue),
		.carry            (carry_q.blue),
		.above            (above.blue),
		.part_below       (pbs_q.blue),
		.part_below_right (pbrs_q.blue),
		.pos              (pos_s1),
		.res              (res_b)
	);

	assign wdata   = '{red: res_r.below_left, green: res_g.below_left,
		blue: res_b.below_left};
	assign mem_we  = adv && pos_s1.has_below && !pos_s1.first_col;
	assign tail_we = adv && pos_s1.has_below && !pos_s1.has_right;

	// carries and partial sums advance as each word leaves the compute stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
			pbs_q   <= '0;
			pbrs_q  <= '0;
		end else if (restart) begin
			carry_q <= '0;
			pbs_q   <= '0;
			pbrs_q  <= '0;
		end else if (adv) begin
			carry_q <= '{red: res_r.right, green: res_g.right, blue: res_b.right};
			pbs_q   <= '{red: res_r.below_sum, green: res_g.below_sum,
				blue: res_b.below_sum};
			pbrs_q  <= '{red: res_r.below_right, green: res_g.below_right,
				blue: res_b.below_right};
		end
	end

	always_ff @(posedge clk) begin
		if (tail_we) begin
			tail_q <= '{red: res_r.below, green: res_g.below, blue: res_b.below};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_word_q.out_red      <= res_r.dot;
			out_word_q.out_green    <= res_g.dot;
			out_word_q.out_blue     <= res_b.dot;
			out_word_q.end_of_frame <= !pos_s1.has_right && !pos_s1.has_below;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

FILE: rtl/rgbed_checker.sv
// ----------------------------------------------------------------------------
// rgbed_checker
// Port-level checks on the dither's stream timing, bound to the top level.
// ----------------------------------------------------------------------------
module rgbed_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input rgbed_pkg::result_t  out_word
);
	import rgbed_pkg::*;

	// an accepted word has a result waiting once it passes the compute and output registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> ##2 out_valid)
		else $error("accepted word produced no result");

	// with the output empty, nothing may hold off the input
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked while output is empty");

	// a result only appears from an earlier accepted word
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without an accepted word");

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_word)))
		else $error("stalled result dropped or changed");

endmodule

bind rgb_error_diffusion_dither rgbed_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_word  (out_word)
);

FILE: verif/rgb_error_diffusion_dither_tb.sv
// ----------------------------------------------------------------------------
// rgb_error_diffusion_dither_tb
// Self-checking bench for the RGB Floyd-Steinberg dither. Pixel words go in
// through a queue-fed driver, and each is run through a local error-diffusion
// predictor. A monitor compares every result word with the oldest prediction.
// Frame sizes and idle/stall mixes change between phases while the block is
// idle.
// ----------------------------------------------------------------------------
module rgb_error_diffusion_dither_tb;
	import rgbed_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int FRAME_BUDGET   = 85;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	pixel_t                in_word = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	result_t               out_word;

	rgb_error_diffusion_dither u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [IMG_W_W-1:0] img_width  = RESET_WIDTH;
	logic [IMG_H_W-1:0] img_height = RESET_HEIGHT;
	int line_err [MAX_WIDTH_DEF][3];
	int err_right [3];
	int acc_below [3];
	int acc_below_right [3];
	int col_pos;
	int row_pos;

	pixel_t  pixel_q [$];
	result_t dot_expect_q [$];
	int pushed_count   = 0;
	int accepted_count = 0;
	int mismatches     = 0;
	int stall_cycles   = 0;
	bit word_taken     = 1'b0;
	bit sender_pause   = 1'b0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int recv_hold      = 0;

	function automatic void clear_frame_state();
		err_right       = '{default: 0};
		acc_below       = '{default: 0};
		acc_below_right = '{default: 0};
		col_pos = 0;
		row_pos = 0;
	endfunction

	function automatic result_t dither_pixel(input pixel_t px);
		int w, h, x, y, c, adj, e, below;
		int sample [3];
		bit dot [3];
		bit has_right, has_below;
		result_t r;
		w = (img_width == 0) ? 1 : (img_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : img_width;
		h = (img_height == 0) ? 1 : img_height;
		x = col_pos;
		y = row_pos;
		has_right = (x + 1 < w);
		has_below = (y + 1 < h);
		sample[0] = px.in_red;
		sample[1] = px.in_green;
		sample[2] = px.in_blue;
		for (c = 0; c < 3; c++) begin
			adj = sample[c] + err_right[c];
			if (y > 0)
				adj += line_err[x][c];
			if (adj < 0)
				adj = 0;
			if (adj > 255)
				adj = 255;
			dot[c] = (adj >= 128);
			e = dot[c] ? adj - 255 : adj;
			err_right[c] = has_right ? (e * 7) / 16 : 0;
			if (has_below) begin
				below = acc_below_right[c] + (e * 5) / 16;
				if (x > 0)
					line_err[x - 1][c] = acc_below[c] + (e * 3) / 16;
				acc_below[c] = below;
				acc_below_right[c] = has_right ? e / 16 : 0;
				// last column: flush the below share straight into the store
				if (!has_right) begin
					line_err[x][c] = below;
					acc_below[c] = 0;
					acc_below_right[c] = 0;
				end
			end else begin
				acc_below[c] = 0;
				acc_below_right[c] = 0;
			end
		end
		r.out_red      = dot[0];
		r.out_green    = dot[1];
		r.out_blue     = dot[2];
		r.end_of_frame = !has_right && !has_below;
		if (r.end_of_frame)
			clear_frame_state();
		else if (!has_right) begin
			col_pos = 0;
			row_pos = y + 1;
			err_right = '{default: 0};
		end else
			col_pos = x + 1;
		return r;
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t p;
		p = pixel_t'($urandom);
		case ($urandom_range(9))
			0: p = '{in_red: {8{p.in_red[0]}}, in_green: {8{p.in_green[0]}},
				in_blue: {8{p.in_blue[0]}}};
			1: p = '{in_red: 8'($urandom_range(120, 136)), in_green: 8'($urandom_range(120, 136)),
				in_blue: 8'($urandom_range(120, 136))};
			default: ;
		endcase
		return p;
	endfunction

	task automatic queue_pixel(input pixel_t p);
		pixel_q.push_back(p);
		pushed_count++;
	endtask

	task automatic queue_rgb(input int r, input int g, input int b);
		queue_pixel('{in_red: 8'(r), in_green: 8'(g), in_blue: 8'(b)});
	endtask

	// block must be idle here; mirror the write into the predictor
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_DATA_W'(data);
		if (idx == CFG_IMAGE_WIDTH) begin
			img_width = IMG_W_W'(data);
			clear_frame_state();
		end else if (idx == CFG_IMAGE_HEIGHT) begin
			img_height = IMG_H_W'(data);
			clear_frame_state();
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_until_idle();
		while (accepted_count != pushed_count || dot_expect_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic run_frames(input int budget);
		int done, w, h, we, he, n, cap;
		done = 0;
		while (done < budget) begin
			case ($urandom_range(9))
				0: w = 0;
				1: w = 1;
				2: w = $urandom_range(1025, 4095);
				default: w = $urandom_range(2, 24);
			endcase
			case ($urandom_range(7))
				0: h = 0;
				1: h = 1;
				2: h = $urandom_range(9, 4095);
				default: h = $urandom_range(2, 8);
			endcase
			if ($urandom_range(1)) begin
				write_register(CFG_IMAGE_WIDTH, w);
				write_register(CFG_IMAGE_HEIGHT, h);
			end else begin
				write_register(CFG_IMAGE_HEIGHT, h);
				write_register(CFG_IMAGE_WIDTH, w);
			end
			if ($urandom_range(7) == 0)
				write_register(CFG_UNUSED_IDX, $urandom_range(4095));
			we = w & 'h7FF;
			we = (we == 0) ? 1 : (we > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : we;
			he = (h == 0) ? 1 : h;
			cap = (we * he * 2 + 3 > 160) ? 160 : we * he * 2 + 3;
			n = $urandom_range(1, cap);
			repeat (n) queue_pixel(random_pixel());
			wait_until_idle();
			done += n;
		end
	endtask

	// driver: present the next pixel word, hold it until taken
	always @(negedge clk) begin
		if (!arst_n)
			in_valid <= 1'b0;
		else if (!in_valid || word_taken) begin
			word_taken = 1'b0;
			if (pixel_q.size() != 0 && !sender_pause && $urandom_range(99) >= send_idle_pct) begin
				in_word  <= pixel_q.pop_front();
				in_valid <= 1'b1;
			end else
				in_valid <= 1'b0;
		end
	end

	// receiver: long hold-off first, random stalls otherwise
	always @(negedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else if (recv_hold != 0) begin
			recv_hold--;
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// monitor: predict on input acceptance, check on output acceptance
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				dot_expect_q.push_back(dither_pixel(in_word));
				word_taken = 1'b1;
				accepted_count++;
			end
			if (out_valid && out_ready) begin
				if (dot_expect_q.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result word: r%0d g%0d b%0d eof%0d",
							out_word.out_red, out_word.out_green, out_word.out_blue,
							out_word.end_of_frame);
					mismatches++;
				end else begin
					want = dot_expect_q.pop_front();
					if (out_word.out_red !== want.out_red || out_word.out_green !== want.out_green
							|| out_word.out_blue !== want.out_blue
							|| out_word.end_of_frame !== want.end_of_frame) begin
						if (mismatches < 10)
							$display("mismatch: expected r%0d g%0d b%0d eof%0d, got r%0d g%0d b%0d eof%0d",
								want.out_red, want.out_green, want.out_blue, want.end_of_frame,
								out_word.out_red, out_word.out_green, out_word.out_blue,
								out_word.end_of_frame);
						mismatches++;
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		foreach (line_err[i, c])
			line_err[i][c] = 0;
		clear_frame_state();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// reset geometry, field extremes and the threshold edges
		queue_rgb(0, 0, 0);
		queue_rgb(255, 255, 255);
		queue_rgb(127, 128, 129);
		queue_rgb(128, 127, 0);
		queue_rgb(255, 0, 128);
		queue_rgb(1, 254, 127);
		wait_until_idle();

		// zero width acts as one column, frame ends every third pixel
		write_register(CFG_IMAGE_WIDTH, 0);
		write_register(CFG_IMAGE_HEIGHT, 3);
		repeat (3) queue_rgb(200, 60, 128);
		queue_rgb(10, 250, 100);
		wait_until_idle();

		// zero height acts as one row
		write_register(CFG_IMAGE_WIDTH, 3);
		write_register(CFG_IMAGE_HEIGHT, 0);
		queue_rgb(90, 170, 255);
		queue_rgb(90, 170, 0);
		queue_rgb(129, 126, 64);
		queue_rgb(33, 222, 191);
		wait_until_idle();

		// a write past the register list must not restart the frame
		write_register(CFG_IMAGE_HEIGHT, 2);
		queue_rgb(200, 50, 140);
		queue_rgb(60, 190, 100);
		wait_until_idle();
		write_register(CFG_UNUSED_IDX, 12'h5A5);
		queue_rgb(250, 5, 128);
		queue_rgb(100, 160, 127);
		queue_rgb(20, 235, 180);
		queue_rgb(140, 115, 75);
		queue_rgb(255, 255, 0);
		wait_until_idle();

		// no idling; receiver holds off long enough to back up the input
		write_register(CFG_IMAGE_WIDTH, 7);
		write_register(CFG_IMAGE_HEIGHT, 5);
		recv_hold = 300;
		repeat (40) queue_pixel(random_pixel());
		wait_until_idle();
		run_frames(FRAME_BUDGET);

		// widest row; width data with bit 11 set still clamps to the maximum
		write_register(CFG_IMAGE_WIDTH, 12'hFFF);
		write_register(CFG_IMAGE_HEIGHT, 12'hFFF);
		repeat (MAX_WIDTH_DEF + 16) queue_pixel(random_pixel());
		wait_until_idle();

		send_idle_pct = 84;
		run_frames(FRAME_BUDGET);

		send_idle_pct  = 0;
		recv_stall_pct = 84;
		run_frames(FRAME_BUDGET);

		send_idle_pct  = 20;
		recv_stall_pct = 20;
		write_register(CFG_IMAGE_WIDTH, 5);
		write_register(CFG_IMAGE_HEIGHT, 4);
		repeat (30) queue_pixel(random_pixel());
		while (accepted_count < pushed_count - 15)
			@(negedge clk);
		// stop offering until every result is back
		sender_pause = 1'b1;
		while (dot_expect_q.size() != 0)
			@(negedge clk);
		sender_pause = 1'b0;
		wait_until_idle();
		run_frames(FRAME_BUDGET);

		wait_until_idle();
		repeat (10) @(negedge clk);
		if (mismatches == 0 && dot_expect_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
